>>> rtl/kdq_pkg.sv
// ----------------------------------------------------------------------------
// kdq_pkg
// Shared types and codes for the keyed deque: operation and status codes,
// the stored entry and the per-cycle command that goes to every cell.
// ----------------------------------------------------------------------------
package kdq_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned PosW  = 5;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StatW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_RM_HEAD = 3'd1,
    OP_RM_TAIL = 3'd2,
    OP_RM_KEY = 3'd3,
    OP_DECR = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PosW-1:0] pos;
  } entry_t;

  // one command per accepted transaction, broadcast along the chain
  typedef struct packed {
    logic           ins;
    logic           rm_head;
    logic           rm_tail;
    logic           rm_key;
    logic           decr;
    logic [IdW-1:0] key;
  } cell_ctl_t;

endpackage

>>> rtl/kdq_cell.sv
// ----------------------------------------------------------------------------
// kdq_cell
// One slot of the deque. Holds an id and a position, compares its id with
// the key, and takes data from its left or right neighbor on insert/remove.
// ----------------------------------------------------------------------------
module kdq_cell import kdq_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occ_i,      // slot lies below the entry count
  input  logic      tail_i,     // slot is the current tail
  input  entry_t    left_i,
  input  entry_t    right_i,
  input  logic      hit_i,      // a slot nearer the head was selected
  output logic      hit_o,
  output logic      sel_o,
  output logic      tail_hit_o,
  output entry_t    removed_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;
  logic   match;

  assign entry_o = entry_q;

  always_comb begin
    match      = occ_i && (entry_q.id == ctl_i.key);
    sel_o      = (occ_i && !hit_i && (ctl_i.rm_head || (ctl_i.rm_key && match)))
                 || (ctl_i.rm_tail && tail_i);
    hit_o      = hit_i || sel_o;
    tail_hit_o = sel_o && tail_i;
    removed_o  = sel_o ? entry_q : '0;
  end

  always_comb begin
    entry_d = entry_q;
    priority if (ctl_i.ins) begin
      entry_d = left_i;
    end else if (hit_o) begin
      // close the gap left by the removed slot
      entry_d = right_i;
    end else if (ctl_i.decr && (entry_q.pos != '0)) begin
      entry_d.pos = entry_q.pos - PosW'(1);
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> rtl/keyed_deque_with_positions_unit.sv
// ----------------------------------------------------------------------------
// keyed_deque_with_positions_unit
// Ordered deque of client ids with per-entry position numbers.
//
// Accepts one transaction per clock cycle and presents its result in the
// output register on the next cycle; the input stays ready while that
// register is empty or being drained. Every operation is carried out on a
// row of DEPTH cells: each cell compares its id with the key and
// decrements its position in parallel, and the first-match flag ripples from
// head to tail through the chain, which sets the critical path. No clearing
// pass is needed after reset: only slots below the entry count are ever
// read. Insert on a full deque returns status full and changes nothing.
// ----------------------------------------------------------------------------
module keyed_deque_with_positions_unit import kdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // operation[2:0], client_id[18:3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[1:0], removed_valid[2],
                                     // removed_id[18:3], removed_position[23:19],
                                     // marked_out[24], assigned_position[29:25],
                                     // entry_count[34:30], zero pad
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [39:0]     out_q, out_d;

  logic            accept;
  op_e             op;
  logic [IdW-1:0]  key;
  logic            empty, full;
  cell_ctl_t       ctl;

  entry_t          entry_of [DEPTH];
  entry_t          left     [DEPTH];
  entry_t          right    [DEPTH];
  entry_t          removed  [DEPTH];
  logic [DEPTH:0]  hit;
  logic [DEPTH-1:0] sel, tail_hit, occ, tail;

  entry_t          rem_ent;
  logic            rem_valid, tail_taken, marked;
  logic [31:0]     inc32, cnt32;
  logic [PosW-1:0] new_pos, assigned;
  status_e         status;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign op            = op_e'(s_axis_tdata[OpW-1:0]);
  assign key           = s_axis_tdata[OpW+IdW-1:OpW];

  assign empty   = (count_q == '0);
  assign full    = (count_q == CntW'(DEPTH));
  assign inc32   = 32'(count_q) + 32'd1;
  assign new_pos = inc32[PosW-1:0];

  always_comb begin
    ctl         = '0;
    ctl.key     = key;
    ctl.ins     = accept && (op == OP_INSERT) && !full;
    ctl.rm_head = accept && (op == OP_RM_HEAD);
    ctl.rm_tail = accept && (op == OP_RM_TAIL);
    ctl.rm_key  = accept && (op == OP_RM_KEY);
    ctl.decr    = accept && (op == OP_DECR);
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i]   = (CntW'(i) < count_q);
    assign tail[i]  = (count_q == CntW'(i + 1));
    assign left[i]  = (i == 0) ? entry_t'{id: key, pos: new_pos} : entry_of[(i == 0) ? 0 : i-1];
    assign right[i] = entry_of[(i == DEPTH-1) ? i : i+1];

    kdq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (occ[i]),
      .tail_i     (tail[i]),
      .left_i     (left[i]),
      .right_i    (right[i]),
      .hit_i      (hit[i]),
      .hit_o      (hit[i+1]),
      .sel_o      (sel[i]),
      .tail_hit_o (tail_hit[i]),
      .removed_o  (removed[i]),
      .entry_o    (entry_of[i])
    );
  end

  // pick out the removed entry, at most one cell drives non-zero
  always_comb begin
    rem_ent = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      rem_ent = rem_ent | removed[i];
    end
  end

  assign rem_valid  = hit[DEPTH];
  assign tail_taken = |tail_hit;
  // a key hit at the head goes through the head path, even for one entry
  assign marked     = ctl.rm_tail ? rem_valid : (ctl.rm_key && tail_taken && !sel[0]);

  always_comb begin
    status  = ST_DONE;
    count_d = count_q;
    unique case (op)
      OP_INSERT: begin
        if (full) status = ST_FULL;
        else count_d = count_q + CntW'(1);
      end
      OP_RM_HEAD, OP_RM_TAIL: begin
        if (empty) status = ST_EMPTY;
        else count_d = count_q - CntW'(1);
      end
      OP_RM_KEY: begin
        if (empty) status = ST_EMPTY;
        else if (!rem_valid) status = ST_MISS;
        else count_d = count_q - CntW'(1);
      end
      OP_DECR: status = ST_DONE;
      default: status = ST_DONE;
    endcase
  end

  assign cnt32    = 32'(count_d);
  assign assigned = ctl.ins ? new_pos : '0;

  always_comb begin
    out_d        = '0;
    out_d[1:0]   = status;
    out_d[2]     = rem_valid;
    out_d[18:3]  = rem_ent.id;
    out_d[23:19] = rem_ent.pos;
    out_d[24]    = marked;
    out_d[29:25] = assigned;
    out_d[34:30] = cnt32[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_one_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel))
    else $error("more than one cell selected for removal");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the deque");

  a_rm_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q[2]) |-> (out_q[1:0] == ST_DONE))
    else $error("removal reported with non-done status");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_deque_with_positions_unit. A short table of
// directed operations covers the empty, miss and position-floor cases. Random
// operations follow, mostly fill and drain sequences. Every result is compared
// per field against a known table result or an in-bench deque predictor, under
// random source and sink idling and a long sink hold-off over inserts past full.
// ----------------------------------------------------------------------------
module testbench;
  import kdq_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned LONG_HOLD = 300;

  // operation codes the block treats as no-ops
  localparam logic [OpW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;

  // result word, fields from the highest bit down as on m_axis_tdata
  typedef struct packed {
    logic [4:0]      pad;
    logic [PosW-1:0] count;
    logic [PosW-1:0] asg_pos;
    logic            marked_out;
    logic [PosW-1:0] rm_pos;
    logic [IdW-1:0]  rm_id;
    logic            rm_vld;
    status_e         status;
  } deque_resp_t;

  typedef struct {
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    bit             known;
    deque_resp_t    resp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // operation[2:0], client_id[18:3], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status[1:0], removed_valid[2],
                                    // removed_id[18:3], removed_position[23:19],
                                    // marked_out[24], assigned_position[29:25],
                                    // entry_count[34:30], zero pad

  entry_t      deque_q[$];
  deque_resp_t resp_expect_q[$];
  dir_row_t    dir_tbl[25];
  int unsigned mismatch_cnt  = 0;
  int unsigned src_idle_pct  = 26;
  int unsigned dst_idle_pct  = 51;
  bit          filling       = 1'b1;
  bit          hold_req_tgl  = 1'b0;
  bit          hold_ack_tgl  = 1'b0;
  int unsigned hold_left     = 0;

  keyed_deque_with_positions_unit #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #(2_000_000);
    $display("keyed_deque_with_positions_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void unlink_entry(int idx, bit tail_path, inout deque_resp_t r);
    r.rm_vld     = 1'b1;
    r.rm_id      = deque_q[idx].id;
    r.rm_pos     = deque_q[idx].pos;
    r.marked_out = tail_path;
    deque_q.delete(idx);
  endfunction

  function automatic deque_resp_t deque_step(logic [OpW-1:0] op, logic [IdW-1:0] id);
    deque_resp_t r;
    int          hit;
    r        = '0;
    r.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (deque_q.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.asg_pos = PosW'(deque_q.size() + 1);
          deque_q.push_front('{id: id, pos: r.asg_pos});
        end
      end
      OP_RM_HEAD, OP_RM_TAIL: begin
        if (deque_q.size() == 0) r.status = ST_EMPTY;
        else if (op == OP_RM_HEAD) unlink_entry(0, 1'b0, r);
        else unlink_entry(deque_q.size() - 1, 1'b1, r);
      end
      OP_RM_KEY: begin
        if (deque_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < deque_q.size(); i++) begin
            if (hit < 0 && deque_q[i].id == id) hit = i;
          end
          // a head match wins over the tail path, even for a single entry
          if (hit == 0) unlink_entry(0, 1'b0, r);
          else if (hit < 0) r.status = ST_MISS;
          else unlink_entry(hit, hit == deque_q.size() - 1, r);
        end
      end
      OP_DECR: begin
        for (int i = 0; i < deque_q.size(); i++) begin
          if (deque_q[i].pos != 0) deque_q[i].pos = deque_q[i].pos - 1'b1;
        end
      end
      default: ;
    endcase
    r.count = PosW'(deque_q.size());
    return r;
  endfunction

  function automatic deque_resp_t known_resp(status_e st, logic [PosW-1:0] asg,
                                             logic [PosW-1:0] cnt);
    deque_resp_t r;
    r         = '0;
    r.status  = st;
    r.asg_pos = asg;
    r.count   = cnt;
    return r;
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    deque_resp_t act;
    deque_resp_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = deque_resp_t'(m_axis_tdata);
      if (resp_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        exp = resp_expect_q.pop_front();
        check_field("status", exp.status, act.status);
        check_field("removed_valid", exp.rm_vld, act.rm_vld);
        check_field("removed_id", exp.rm_id, act.rm_id);
        check_field("removed_position", exp.rm_pos, act.rm_pos);
        check_field("marked_out", exp.marked_out, act.marked_out);
        check_field("assigned_position", exp.asg_pos, act.asg_pos);
        check_field("entry_count", exp.count, act.count);
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (hold_req_tgl != hold_ack_tgl) begin
      hold_ack_tgl  <= hold_req_tgl;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // ------------------------------------------------------------------- sender

  // called and returns at a falling edge
  task automatic send_op(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                         input bit known, input deque_resp_t known_r);
    deque_resp_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = deque_step(op, id);
    resp_expect_q.push_back(known ? known_r : pred);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned n_ops);
    int unsigned    r;
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    for (int unsigned k = 0; k < n_ops; k++) begin
      if (deque_q.size() == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if (deque_q.size() == 0) filling = 1'b1;
      else if ($urandom_range(99) == 0) filling = !filling;
      r  = $urandom_range(99);
      id = $urandom_range(1) ? IdW'($urandom_range(7)) : IdW'($urandom_range(16'hFFFF));
      if (r < 3) begin
        op = OP_SPARE5 + OpW'($urandom_range(2));
      end else if (r < 13) begin
        op = OP_DECR;
      end else if (r < (filling ? 70 : 30)) begin
        op = OP_INSERT;
      end else begin
        r = $urandom_range(9);
        if (r < 6) begin
          op = OP_RM_KEY;
          if (deque_q.size() != 0 && $urandom_range(9) < 7) begin
            id = deque_q[$urandom_range(deque_q.size() - 1)].id;
          end
        end else if (r < 8) begin
          op = OP_RM_HEAD;
        end else begin
          op = OP_RM_TAIL;
        end
      end
      send_op(op, id, 1'b0, '0);
    end
  endtask

  initial begin
    dir_tbl = '{
      '{OP_RM_HEAD, 16'h0000, 1'b1, known_resp(ST_EMPTY, 5'd0, 5'd0)},
      '{OP_RM_TAIL, 16'hFFFF, 1'b1, known_resp(ST_EMPTY, 5'd0, 5'd0)},
      '{OP_RM_KEY,  16'h0000, 1'b1, known_resp(ST_EMPTY, 5'd0, 5'd0)},
      '{OP_DECR,    16'h0000, 1'b1, known_resp(ST_DONE,  5'd0, 5'd0)},
      '{OP_SPARE5,  16'hFFFF, 1'b1, known_resp(ST_DONE,  5'd0, 5'd0)},
      '{OP_SPARE6,  16'h8001, 1'b1, known_resp(ST_DONE,  5'd0, 5'd0)},
      '{OP_SPARE7,  16'h7FFE, 1'b1, known_resp(ST_DONE,  5'd0, 5'd0)},
      '{OP_INSERT,  16'h0000, 1'b1, known_resp(ST_DONE,  5'd1, 5'd1)},
      '{OP_INSERT,  16'hFFFF, 1'b1, known_resp(ST_DONE,  5'd2, 5'd2)},
      '{OP_INSERT,  16'hAAAA, 1'b0, '0},
      '{OP_INSERT,  16'h5555, 1'b0, '0},
      '{OP_INSERT,  16'h0001, 1'b0, '0},
      '{OP_DECR,    16'h0000, 1'b0, '0},
      // middle, tail, then head match
      '{OP_RM_KEY,  16'hAAAA, 1'b0, '0},
      '{OP_RM_KEY,  16'h0000, 1'b0, '0},
      '{OP_RM_KEY,  16'h0001, 1'b0, '0},
      '{OP_RM_KEY,  16'h7777, 1'b1, known_resp(ST_MISS,  5'd0, 5'd2)},
      // duplicate id, the first one from the head goes
      '{OP_INSERT,  16'h5555, 1'b0, '0},
      '{OP_RM_KEY,  16'h5555, 1'b0, '0},
      // positions run down to zero and stay there
      '{OP_DECR,    16'h0000, 1'b0, '0},
      '{OP_DECR,    16'h0000, 1'b0, '0},
      '{OP_DECR,    16'h0000, 1'b0, '0},
      '{OP_RM_TAIL, 16'h1234, 1'b0, '0},
      // single entry is both head and tail
      '{OP_RM_KEY,  16'h5555, 1'b0, '0},
      '{OP_RM_HEAD, 16'h0000, 1'b1, known_resp(ST_EMPTY, 5'd0, 5'd0)}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) send_op(dir_tbl[i].op, dir_tbl[i].id, dir_tbl[i].known, dir_tbl[i].resp);

    // sink stalls for a long stretch while inserts keep coming, past full
    hold_req_tgl = !hold_req_tgl;
    for (int i = 0; i < 20; i++) send_op(OP_INSERT, IdW'($urandom_range(16'hFFFF)), 1'b0, '0);

    run_random(520);
    src_idle_pct = 51;
    dst_idle_pct = 26;
    run_random(520);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random(515);

    s_axis_tvalid <= 1'b0;
    while (resp_expect_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("keyed_deque_with_positions_unit verification clean");
    end else begin
      $display("keyed_deque_with_positions_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/kdq_pkg.sv
rtl/kdq_cell.sv
rtl/keyed_deque_with_positions_unit.sv
tb/sv/testbench.sv
